FILE: design/ctdn_pkg.sv
// Shared types, constants and the restoring-division step for the
// clock-tick to epoch-nanosecond converter. No dependencies.
package ctdn_pkg;

  // Fixed arithmetic constants.
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [33:0] FREQ_MAX   = 34'd9223372036;
  localparam logic [33:0] FREQ_RESET = 34'd1000000000;
  // Largest quotient magnitude whose product with one billion fits in 64 signed bits.
  localparam logic [63:0] QMAG_MAX   = 64'd9223372036;

  // Divider depths: one quotient bit per stage.
  localparam int QDIV_STEPS = 64;
  localparam int RDIV_STEPS = 30;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FREQ      = 2'd0;
  localparam logic [1:0] CFG_REF_TICKS = 2'd1;
  localparam logic [1:0] CFG_REF_NS    = 2'd2;

  // Sign and magnitude of the tick difference.
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } front_t;

  // One stage of the tick divider: dividend bits shift out of work while
  // quotient bits shift in.
  typedef struct packed {
    logic        neg;
    logic [63:0] work;
    logic [33:0] rem;
  } qdiv_t;

  // One stage of the remainder divider; the tick quotient rides along.
  typedef struct packed {
    logic                  neg;
    logic [63:0]           qmag;
    logic [RDIV_STEPS-1:0] work;
    logic [33:0]           rem;
  } rdiv_t;

  // Final result beat.
  typedef struct packed {
    logic        ovf;
    logic [63:0] ns;
  } result_t;

  // One restoring-division step. The partial remainder is always below the
  // divisor, so the trial difference never needs more than 35 bits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [34:0] div_step(logic [33:0] rem, logic din,
                                           logic [33:0] divisor);
    logic [34:0] trial;
    logic [34:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, divisor};
    if (!diff[34]) begin
      return {1'b1, diff[33:0]};
    end
    return {1'b0, trial[33:0]};
  endfunction

endpackage

FILE: design/ctdn_front.sv
// Input stages: tick difference against the reference reading, then sign
// and magnitude. Depends on ctdn_pkg.
module ctdn_front import ctdn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [63:0] in_ticks,
  input  logic [63:0] ref_ticks,
  output logic        out_vld,
  output front_t      dout
);

  logic        diff_vld;
  logic [63:0] diff;

  // Valid bits move with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else if (adv) begin
      diff_vld <= in_vld;
      out_vld  <= diff_vld;
    end
  end

  // Wrapping difference, then absolute value with the sign kept aside.
  always_ff @(posedge clk) begin
    if (adv) begin
      diff     <= in_ticks - ref_ticks;
      dout.neg <= diff[63];
      dout.mag <= diff[63] ? (~diff + 64'd1) : diff;
    end
  end

endmodule

FILE: design/ctdn_qdiv.sv
// Pipelined restoring divider for the tick magnitude by the clock frequency,
// one quotient bit per stage. Depends on ctdn_pkg.
module ctdn_qdiv import ctdn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  front_t      din,
  input  logic [33:0] freq,
  output logic        out_vld,
  output qdiv_t       dout
);

  qdiv_t                 st  [QDIV_STEPS];
  qdiv_t                 nxt [QDIV_STEPS];
  logic [QDIV_STEPS-1:0] vld;

  // Each stage takes the next dividend bit from the top of work.
  always_comb begin
    qdiv_t       cur;
    logic [34:0] step;
    for (int i = 0; i < QDIV_STEPS; i++) begin
      if (i == 0) begin
        cur.neg  = din.neg;
        cur.work = din.mag;
        cur.rem  = '0;
      end else begin
        cur = st[i-1];
      end
      step        = div_step(cur.rem, cur.work[63], freq);
      nxt[i].neg  = cur.neg;
      nxt[i].work = {cur.work[62:0], step[34]};
      nxt[i].rem  = step[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[QDIV_STEPS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < QDIV_STEPS; i++) begin
        st[i] <= nxt[i];
      end
    end
  end

  assign out_vld = vld[QDIV_STEPS-1];
  assign dout    = st[QDIV_STEPS-1];

endmodule

FILE: design/ctdn_rdiv.sv
// Scales the remainder magnitude by one billion and divides it by the clock
// frequency in a pipelined restoring divider. Depends on ctdn_pkg.
module ctdn_rdiv import ctdn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  qdiv_t       din,
  input  logic [33:0] freq,
  output logic        out_vld,
  output rdiv_t       dout
);

  rdiv_t               st  [RDIV_STEPS+1];
  rdiv_t               nxt [RDIV_STEPS+1];
  logic [RDIV_STEPS:0] vld;
  logic [63:0]         prod;

  // The product stays below freq * 1e9 < freq * 2^30, so its bits above the
  // low thirty already form a partial remainder below the divisor and only
  // thirty quotient bits remain to be found.
  always_comb begin
    rdiv_t       cur;
    logic [34:0] step;
    prod        = {30'b0, din.rem} * {34'b0, NS_PER_SEC};
    nxt[0].neg  = din.neg;
    nxt[0].qmag = din.work;
    nxt[0].work = prod[RDIV_STEPS-1:0];
    nxt[0].rem  = prod[63:RDIV_STEPS];
    for (int i = 1; i <= RDIV_STEPS; i++) begin
      cur         = st[i-1];
      step        = div_step(cur.rem, cur.work[RDIV_STEPS-1], freq);
      nxt[i].neg  = cur.neg;
      nxt[i].qmag = cur.qmag;
      nxt[i].work = {cur.work[RDIV_STEPS-2:0], step[34]};
      nxt[i].rem  = step[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[RDIV_STEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= RDIV_STEPS; i++) begin
        st[i] <= nxt[i];
      end
    end
  end

  assign out_vld = vld[RDIV_STEPS];
  assign dout    = st[RDIV_STEPS];

endmodule

FILE: design/ctdn_back.sv
// Scales the tick quotient by one billion in two partial products, restores
// signs, adds the scaled remainder and the reference time, and tracks signed
// overflow. Depends on ctdn_pkg.
module ctdn_back import ctdn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  rdiv_t       din,
  input  logic [63:0] ref_ns,
  output logic        out_vld,
  output result_t     dout
);

  logic [4:0]            vld;

  logic [61:0]           s1_lo;
  logic [31:0]           s1_qhi;
  logic                  s1_neg;
  logic                  s1_ovf;
  logic [RDIV_STEPS-1:0] s1_sq;

  logic [61:0]           s2_lo;
  logic [31:0]           s2_hi;
  logic                  s2_neg;
  logic                  s2_ovf;
  logic [RDIV_STEPS-1:0] s2_sq;

  logic [63:0]           s3_pm;
  logic                  s3_neg;
  logic                  s3_ovf;
  logic [RDIV_STEPS-1:0] s3_sq;

  logic [63:0]           s4_p;
  logic [63:0]           s4_sr;
  logic                  s4_ovf;

  logic [63:0]           s5_sum;
  logic                  s5_ovf;

  logic [61:0]           hi_prod;
  logic [63:0]           pm;
  logic [63:0]           sq_ext;
  logic [63:0]           sum5;
  logic [63:0]           sum6;
  logic                  add5_ovf;
  logic                  add6_ovf;

  // Arithmetic between the stage registers.
  always_comb begin
    hi_prod  = {30'b0, s1_qhi} * {32'b0, NS_PER_SEC};
    pm       = {2'b0, s2_lo} + {s2_hi, 32'b0};
    sq_ext   = {{(64-RDIV_STEPS){1'b0}}, s3_sq};
    sum5     = s4_p + s4_sr;
    sum6     = s5_sum + ref_ns;
    add5_ovf = (s4_p[63] == s4_sr[63]) && (sum5[63] != s4_p[63]);
    add6_ovf = (s5_sum[63] == ref_ns[63]) && (sum6[63] != s5_sum[63]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[3:0], in_vld};
      out_vld <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Low partial product and the range check on the quotient.
      s1_lo  <= {30'b0, din.qmag[31:0]} * {32'b0, NS_PER_SEC};
      s1_qhi <= din.qmag[63:32];
      s1_neg <= din.neg;
      s1_ovf <= din.qmag > QMAG_MAX;
      s1_sq  <= din.work;
      // High partial product; only its low word survives the 2^32 shift.
      s2_lo  <= s1_lo;
      s2_hi  <= hi_prod[31:0];
      s2_neg <= s1_neg;
      s2_ovf <= s1_ovf;
      s2_sq  <= s1_sq;
      // Scaled magnitude modulo 2^64.
      s3_pm  <= pm;
      s3_neg <= s2_neg;
      s3_ovf <= s2_ovf;
      s3_sq  <= s2_sq;
      // Both terms take the sign of the tick difference.
      s4_p   <= s3_neg ? (~s3_pm + 64'd1) : s3_pm;
      s4_sr  <= s3_neg ? (~sq_ext + 64'd1) : sq_ext;
      s4_ovf <= s3_ovf;
      // Add the scaled remainder.
      s5_sum <= sum5;
      s5_ovf <= s4_ovf | add5_ovf;
      // Add the reference time.
      dout.ns  <= sum6;
      dout.ovf <= s5_ovf | add6_ovf;
    end
  end

endmodule

FILE: design/clock_ticks_to_epoch_ns.sv
// Top level of the clock-tick to epoch-nanosecond converter: configuration
// registers, the pipeline and the output register with its skid stage.
// Depends on ctdn_pkg, ctdn_front, ctdn_qdiv, ctdn_rdiv and ctdn_back.
//
// Each beat on the slave side is a 64-bit clock reading; each beat on the
// master side is its time in nanoseconds since the epoch, plus an overflow
// flag in tuser. The block takes one reading per clock while s_tready is high
// and returns results in order through 2 difference stages, 64 stages of the
// tick divider, 31 stages of remainder scaling and division, 6 stages of
// scaling and addition, and the output register. The depth is set by the two
// restoring dividers, which find one quotient bit per stage. When the output
// is stalled the pipeline keeps moving until one more result sits in the skid
// stage; only then does s_tready drop. Write the configuration registers only
// while no conversion is in flight.
module clock_ticks_to_epoch_ns import ctdn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Clock readings.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] clock_value
  // Converted times.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] ns_since_epoch
  output logic        m_tuser,   // [0] overflow
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [33:0] freq;
  logic [63:0] ref_ticks;
  logic [63:0] ref_ns;
  logic [33:0] freq_raw;
  logic [33:0] freq_wr;

  logic        adv;
  logic        front_vld;
  front_t      front_d;
  logic        qdiv_vld;
  qdiv_t       qdiv_d;
  logic        rdiv_vld;
  rdiv_t       rdiv_d;
  logic        res_vld;
  result_t     res;

  result_t     out_r;
  result_t     skid;
  logic        skid_full;

  // A zero frequency is stored as one, an oversized one is clamped.
  always_comb begin
    freq_raw = cfg_data[33:0];
    if (freq_raw == 34'd0) begin
      freq_wr = 34'd1;
    end else if (freq_raw > FREQ_MAX) begin
      freq_wr = FREQ_MAX;
    end else begin
      freq_wr = freq_raw;
    end
  end

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq      <= FREQ_RESET;
      ref_ticks <= '0;
      ref_ns    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FREQ:      freq      <= freq_wr;
        CFG_REF_TICKS: ref_ticks <= cfg_data;
        CFG_REF_NS:    ref_ns    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless the skid stage is occupied.
  assign adv      = !skid_full;
  assign s_tready = adv;

  ctdn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_vld    (s_tvalid),
    .in_ticks  (s_tdata),
    .ref_ticks (ref_ticks),
    .out_vld   (front_vld),
    .dout      (front_d)
  );

  ctdn_qdiv u_qdiv (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (front_vld),
    .din     (front_d),
    .freq    (freq),
    .out_vld (qdiv_vld),
    .dout    (qdiv_d)
  );

  ctdn_rdiv u_rdiv (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (qdiv_vld),
    .din     (qdiv_d),
    .freq    (freq),
    .out_vld (rdiv_vld),
    .dout    (rdiv_d)
  );

  ctdn_back u_back (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (rdiv_vld),
    .din     (rdiv_d),
    .ref_ns  (ref_ns),
    .out_vld (res_vld),
    .dout    (res)
  );

  // Output register and skid control. A result leaving the pipeline while
  // the output beat is stalled parks in the skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (m_tready) begin
        skid_full <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= res_vld;
    end else if (res_vld) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (m_tready) begin
        out_r <= skid;
      end
    end else if (!m_tvalid || m_tready) begin
      if (res_vld) begin
        out_r <= res;
      end
    end else if (res_vld) begin
      skid <= res;
    end
  end

  assign m_tdata = out_r.ns;
  assign m_tuser = out_r.ovf;

endmodule

FILE: design/ctdn_checker.sv
// Port-level checks for the converter and the bind that attaches them to the
// top level. Sees only the top-level ports.
module ctdn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result beat holds its value and flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // Back-pressure on the input only happens while a result is waiting.
  a_ready_needs_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input blocked with no result pending");

  // Input ready only drops when the output was stalled in the cycle before.
  a_ready_drop_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("input ready dropped without an output stall");

endmodule

bind clock_ticks_to_epoch_ns ctdn_checker u_ctdn_checker (.*);

FILE: sim/tb_clock_ticks_to_epoch_ns.sv
// Self-checking testbench for clock_ticks_to_epoch_ns: a directed table of readings
// and register writes, then random phases under bursty input and output stalls.
// Depends on ctdn_pkg and the clock_ticks_to_epoch_ns top level.
module tb_clock_ticks_to_epoch_ns import ctdn_pkg::*; ();

  localparam longint    NS_PER_SEC_S = 64'sd1000000000;
  localparam longint    QUOT_LIMIT   = 64'sd9223372036;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam logic [63:0] S64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int        RANDOM_PHASES = 10;
  localparam int        READINGS_PER_PHASE = 85;

  // One row of the directed table: a register write or a reading.
  typedef struct packed {
    logic        is_write;
    logic [1:0]  index;
    logic [63:0] value;
    logic        known;
    logic [63:0] known_ns;
    logic        known_ovf;
  } step_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // Shadow copy of the configuration registers.
  logic [33:0] freq_reg;
  logic [63:0] ref_ticks_reg;
  logic [63:0] ref_ns_reg;

  result_t     pending_times[$];
  step_row_t   directed_rows[$];
  int          mismatches;
  int          burst_left;

  clock_ticks_to_epoch_ns u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("clock_ticks_to_epoch_ns test failed");
    $finish;
  end

  // True when a two's complement sum wrapped.
  function automatic logic sum_wraps(longint a, longint b, longint s);
    return (a[63] == b[63]) && (s[63] != a[63]);
  endfunction

  // Expected time and overflow flag for one clock reading.
  function automatic result_t epoch_ns_of(logic [63:0] reading);
    longint  diff;
    longint  freq;
    longint  quot;
    longint  rem;
    longint  scaled_rem;
    longint  scaled;
    longint  partial;
    longint  total;
    longint  offset;
    result_t res;
    diff       = $signed(reading - ref_ticks_reg);
    freq       = $signed({30'd0, freq_reg});
    offset     = $signed(ref_ns_reg);
    quot       = diff / freq;
    rem        = diff % freq;
    scaled_rem = (rem * NS_PER_SEC_S) / freq;
    scaled     = quot * NS_PER_SEC_S;
    partial    = scaled + scaled_rem;
    total      = partial + offset;
    res.ovf    = (quot > QUOT_LIMIT) || (quot < -QUOT_LIMIT);
    if (!res.ovf && sum_wraps(scaled, scaled_rem, partial)) begin
      res.ovf = 1'b1;
    end
    if (!res.ovf && sum_wraps(partial, offset, total)) begin
      res.ovf = 1'b1;
    end
    res.ns = total;
    return res;
  endfunction

  function automatic void add_write(logic [1:0] index, logic [63:0] value);
    directed_rows.push_back({1'b1, index, value, 1'b0, 64'd0, 1'b0});
  endfunction

  function automatic void add_reading(logic [63:0] value);
    directed_rows.push_back({1'b0, CFG_FREQ, value, 1'b0, 64'd0, 1'b0});
  endfunction

  function automatic void add_known(logic [63:0] value, logic [63:0] ns, logic ovf);
    directed_rows.push_back({1'b0, CFG_FREQ, value, 1'b1, ns, ovf});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Stop sending and wait for every conversion in flight to come out.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
  endtask

  // One register write, then a pause with the write enable low.
  task automatic write_register(logic [1:0] index, logic [63:0] value);
    logic [33:0] freq;
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_FREQ: begin
        freq = value[33:0];
        if (freq == 34'd0) begin
          freq = 34'd1;
        end
        if (freq > FREQ_MAX) begin
          freq = FREQ_MAX;
        end
        freq_reg = freq;
      end
      CFG_REF_TICKS: ref_ticks_reg = value;
      CFG_REF_NS:    ref_ns_reg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Send one reading in the current burst; the expectation is queued at acceptance.
  task automatic send_reading(logic [63:0] value, logic known, result_t known_res);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (idle != 0) begin
        s_tvalid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    pending_times.push_back(known ? known_res : epoch_ns_of(value));
  endtask

  // Receiver: stretches of full rate, random stalls, short and long holds.
  initial begin
    int mode;
    int span;
    repeat (4) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      if (mode <= 6) begin
        span = $urandom_range(1, 60);
      end else if (mode <= 8) begin
        span = $urandom_range(1, 30);
      end else begin
        span = $urandom_range(60, 200);
      end
      repeat (span) begin
        if (mode <= 3) begin
          m_tready <= 1'b1;
        end else if (mode <= 6) begin
          m_tready <= 1'($urandom_range(0, 1));
        end else begin
          m_tready <= 1'b0;
        end
        @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_times.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result beat: ns=%h ovf=%b", m_tdata, m_tuser);
        end
        mismatches++;
      end else begin
        want = pending_times.pop_front();
        if (m_tdata !== want.ns || m_tuser !== want.ovf) begin
          if (mismatches < 10) begin
            $display("result mismatch: ns expected %h got %h, ovf expected %b got %b",
                     want.ns, m_tdata, want.ovf, m_tuser);
          end
          mismatches++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    step_row_t   row;
    logic [63:0] value;
    logic [63:0] step;
    logic [31:0] word;
    logic [15:0] half;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 64'd0;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_FREQ;
    cfg_data      = 64'd0;
    freq_reg      = FREQ_RESET;
    ref_ticks_reg = 64'd0;
    ref_ns_reg    = 64'd0;
    mismatches    = 0;
    burst_left    = 0;

    // With the reset settings a reading converts to itself.
    add_known(64'd0, 64'd0, 1'b0);
    add_known(64'd1, 64'd1, 1'b0);
    add_known(ALL_ONES, ALL_ONES, 1'b0);
    add_known(S64_MAX, S64_MAX, 1'b0);
    add_known(S64_MIN, S64_MIN, 1'b0);
    add_known(64'd999999999, 64'd999999999, 1'b0);
    // Offset at both extremes: the final addition overflows one step past either.
    add_write(CFG_REF_NS, S64_MAX);
    add_known(64'd1, S64_MIN, 1'b1);
    add_known(64'd0, S64_MAX, 1'b0);
    add_write(CFG_REF_NS, S64_MIN);
    add_known(ALL_ONES, S64_MAX, 1'b1);
    add_known(64'd0, S64_MIN, 1'b0);
    // A write to the unused index leaves everything as it was.
    add_write(CFG_UNUSED, 64'h0123_4567_89AB_CDEF);
    add_known(64'd5, 64'h8000_0000_0000_0005, 1'b0);
    add_write(CFG_REF_NS, 64'd0);
    add_write(CFG_REF_TICKS, 64'd100);
    add_known(64'd99, ALL_ONES, 1'b0);
    add_known(64'd100, 64'd0, 1'b0);
    // A zero frequency is stored as one, so the quotient scaling overflows early.
    add_write(CFG_REF_TICKS, 64'd0);
    add_write(CFG_FREQ, 64'd0);
    add_reading(64'd9223372036);
    add_reading(64'd9223372037);
    add_reading(-64'sd9223372037);
    // Bits above the register width are dropped before the zero check.
    add_write(CFG_FREQ, 64'h0000_0004_0000_0000);
    add_reading(64'd3);
    // Frequencies above range clamp to the largest one.
    add_write(CFG_FREQ, 64'h0000_0003_FFFF_FFFF);
    add_reading(S64_MAX);
    add_reading(ALL_ONES);
    add_write(CFG_FREQ, {30'd0, FREQ_MAX});
    add_reading(64'd9223372036);
    add_reading(S64_MIN);
    add_write(CFG_FREQ, 64'd3);
    add_reading(64'd1);
    add_reading(ALL_ONES);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) begin
        drain_pipeline();
        write_register(row.index, row.value);
      end else begin
        send_reading(row.value, row.known, {row.known_ovf, row.known_ns});
      end
    end

    // Random phases, each under its own settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_pipeline();
      if (p == 0) begin
        value = 64'd1;
      end else if (p == 1) begin
        value = {30'd0, FREQ_MAX};
      end else if (p == 2) begin
        value = 64'd0;
      end else begin
        case ($urandom_range(0, 5))
          0: value = 64'd1000000000;
          1: value = {32'd0, $urandom_range(1, 1000)};
          2: value = {30'd0, 2'($urandom), $urandom};
          3: value = rand64();
          4: value = {32'd0, $urandom_range(1000000, 1000000000)};
          default: value = {30'd0, FREQ_MAX};
        endcase
      end
      write_register(CFG_FREQ, value);
      case ($urandom_range(0, 3))
        0: value = 64'd0;
        1: value = ALL_ONES;
        default: value = rand64();
      endcase
      write_register(CFG_REF_TICKS, value);
      case ($urandom_range(0, 4))
        0: value = 64'd0;
        1: value = S64_MAX;
        2: value = S64_MIN;
        default: value = rand64();
      endcase
      write_register(CFG_REF_NS, value);
      if ($urandom_range(0, 2) == 0) begin
        write_register(CFG_UNUSED, rand64());
      end

      // Mix of raw readings, readings near the sync point and near whole periods.
      repeat (READINGS_PER_PHASE) begin
        word = $urandom;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: value = rand64();
          4, 5, 6, 7: value = ref_ticks_reg + {{32{word[31]}}, word};
          default: begin
            half  = 16'($urandom);
            step  = {{32{word[31]}}, word} * {30'd0, freq_reg};
            value = ref_ticks_reg + step + {{48{half[15]}}, half};
          end
        endcase
        send_reading(value, 1'b0, '0);
      end
    end

    // Let the pipeline empty, then allow for a late or extra beat.
    drain_pipeline();
    repeat (110) @(posedge clk);
    if (mismatches == 0 && pending_times.size() == 0) begin
      $display("clock_ticks_to_epoch_ns test passed");
    end else begin
      $display("clock_ticks_to_epoch_ns test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ctdn_pkg.sv
design/ctdn_front.sv
design/ctdn_qdiv.sv
design/ctdn_rdiv.sv
design/ctdn_back.sv
design/clock_ticks_to_epoch_ns.sv
design/ctdn_checker.sv
sim/tb_clock_ticks_to_epoch_ns.sv
